@@ hdl/dcpd_pkg.sv @@
// Shared constants for the reversing DC motor drive with incremental PD speed loop.
// Phase and side codes, register indexes, reset values and fixed-point widths.
// No dependencies.
`default_nettype none

package dcpd_pkg;

   // fixed-point layout
   localparam int FRAC_BITS  = 8;
   localparam int DUTY_W     = 12;
   localparam int ACC_W      = DUTY_W + FRAC_BITS;  // Q12.8 accumulator
   localparam int GAIN_W     = 16;
   localparam int SPEED_W    = 8;
   localparam int ERR_W      = SPEED_W + 1;         // signed speed error
   localparam int CSR_DATA_W = 16;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INC_LIMIT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MAX   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DUTY_MIN   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_DUTY  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_SPEED = 3'd6;

   // register reset values
   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 16'd256;
   localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 16'd256;
   localparam logic [DUTY_W-1:0]  RST_INC_LIMIT  = 12'd500;
   localparam logic [DUTY_W-1:0]  RST_DUTY_MAX   = 12'd3600;
   localparam logic [DUTY_W-1:0]  RST_DUTY_MIN   = 12'd0;
   localparam logic [DUTY_W-1:0]  RST_STOP_DUTY  = 12'd200;
   localparam logic [SPEED_W-1:0] RST_STOP_SPEED = 8'd5;

   // side request codes
   localparam logic [7:0] REQ_CW  = 8'd0;
   localparam logic [7:0] REQ_CCW = 8'd1;

   // reported side
   localparam logic [1:0] SIDE_NONE = 2'd0;
   localparam logic [1:0] SIDE_CCW  = 2'd1;
   localparam logic [1:0] SIDE_CW   = 2'd2;

   // phase codes
   localparam logic [2:0] PHASE_IDLE      = 3'd0;
   localparam logic [2:0] PHASE_CCW_RUN   = 3'd1;
   localparam logic [2:0] PHASE_CCW_BRAKE = 3'd2;
   localparam logic [2:0] PHASE_CW_RUN    = 3'd3;
   localparam logic [2:0] PHASE_CW_BRAKE  = 3'd4;
   localparam logic [2:0] PHASE_STOPPED   = 3'd5;

   // held direction
   localparam logic DIR_CCW = 1'b0;
   localparam logic DIR_CW  = 1'b1;

   // bridge pins {drive_b, drive_a}
   localparam logic [1:0] PINS_OFF = 2'b00;
   localparam logic [1:0] PINS_CW  = 2'b01;
   localparam logic [1:0] PINS_CCW = 2'b10;

endpackage : dcpd_pkg

`default_nettype wire

@@ hdl/dc_motor_pd_reversing_drive.sv @@
// Reversing DC motor drive: incremental PD speed loop, H-bridge pin and phase control.
// Depends on dcpd_pkg.
//
//  channel | direction | handshake               | beat contents
//  req     | in        | req_valid / req_stall   | side request, target and measured speed
//  rsp     | out       | rsp_valid / rsp_stall   | pins, duty, side, phase, direction
//  csr     | in        | csr_wr_en               | index, write data (no read-back)
//
// One tick per cycle while req_stall is low: a beat is captured in the input register, and
// when the result register can advance, the PD update (16x9 and 16x10 multiplies, increment
// clamp, accumulator add and clamp) writes the control state, also the result register.
// req_stall rises only when the input register is full and the result is held by rsp_stall.
// Reset is synchronous: CSRs and control state reset, and both pipeline stages empty.
`default_nettype none

module dc_motor_pd_reversing_drive
   import dcpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // tick input
   input  wire logic                  req_valid,
   output      logic                  req_stall,
   input  wire logic [7:0]            req_side_request,
   input  wire logic [SPEED_W-1:0]    req_target_speed,
   input  wire logic [SPEED_W-1:0]    req_measured_speed,
   // result
   output      logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   output      logic                  rsp_drive_a,
   output      logic                  rsp_drive_b,
   output      logic [DUTY_W-1:0]     rsp_duty,
   output      logic [1:0]            rsp_reported_side,
   output      logic [2:0]            rsp_phase,
   output      logic                  rsp_direction,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PT_W  = GAIN_W + ERR_W + 1;     // prop term
   localparam int DT_W  = GAIN_W + ERR_W + 2;     // deriv term
   localparam int INC_W = DT_W + 1;               // raw increment
   localparam int LIM_W = ACC_W + 1;              // clamped increment, signed
   localparam int SUM_W = ACC_W + 2;              // accumulator plus increment

   // configuration registers
   logic [GAIN_W-1:0]  prop_gain_ff;
   logic [GAIN_W-1:0]  deriv_gain_ff;
   logic [DUTY_W-1:0]  inc_limit_ff;
   logic [DUTY_W-1:0]  duty_max_ff;
   logic [DUTY_W-1:0]  duty_min_ff;
   logic [DUTY_W-1:0]  stop_duty_ff;
   logic [SPEED_W-1:0] stop_speed_ff;

   // input register
   logic               in_valid_ff, in_valid_in;
   logic [7:0]         side_ff;
   logic [SPEED_W-1:0] target_ff;
   logic [SPEED_W-1:0] meas_ff;

   // control state; also the result register
   logic               out_valid_ff, out_valid_in;
   logic               dir_ff, dir_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;
   logic [ACC_W-1:0]   accum_ff, accum_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [1:0]         pins_ff, pins_in;
   logic [1:0]         side_rep_ff, side_rep_in;
   logic [2:0]         phase_ff, phase_in;

   logic req_take;
   logic advance;

   // tick decode
   logic ccw_run, ccw_brake, cw_run, cw_brake, any_side, brake, stop_now;

   // PD datapath
   logic [SPEED_W-1:0]      pd_target;
   logic signed [ERR_W-1:0] err;
   logic signed [ERR_W:0]   d_err;
   logic signed [PT_W-1:0]  p_term;
   logic signed [DT_W-1:0]  d_term;
   logic signed [INC_W-1:0] inc_raw;
   logic signed [INC_W-1:0] lim_pos;
   logic signed [INC_W-1:0] lim_neg;
   logic signed [LIM_W-1:0] inc_clamped;
   logic signed [SUM_W-1:0] acc_sum;
   logic signed [SUM_W-1:0] acc_hi;
   logic signed [SUM_W-1:0] acc_lo;
   logic [ACC_W-1:0]        acc_new;

   // handshake
   assign advance     = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall   = in_valid_ff & out_valid_ff & rsp_stall;
   assign req_take    = req_valid & ~req_stall;
   assign in_valid_in = req_take | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & rsp_stall);

   // decode of the held direction against the requested side
   assign ccw_run   = (side_ff == REQ_CCW) && (dir_ff == DIR_CCW);
   assign ccw_brake = (side_ff == REQ_CW)  && (dir_ff == DIR_CCW);
   assign cw_run    = (side_ff == REQ_CW)  && (dir_ff == DIR_CW);
   assign cw_brake  = (side_ff == REQ_CCW) && (dir_ff == DIR_CW);
   assign any_side  = ccw_run | ccw_brake | cw_run | cw_brake;
   assign brake     = ccw_brake | cw_brake;
   assign stop_now  = (brake && (meas_ff <= stop_speed_ff))
                      || (!any_side && (target_ff == '0));

   // PD increment; braking drives toward zero speed
   assign pd_target = brake ? '0 : target_ff;
   assign err   = $signed({1'b0, pd_target}) - $signed({1'b0, meas_ff});
   assign d_err = {err[ERR_W-1], err} - {prev_err_ff[ERR_W-1], prev_err_ff};
   assign p_term = $signed({{(PT_W-GAIN_W){1'b0}}, prop_gain_ff})
                   * $signed({{(PT_W-ERR_W){err[ERR_W-1]}}, err});
   assign d_term = $signed({{(DT_W-GAIN_W){1'b0}}, deriv_gain_ff})
                   * $signed({{(DT_W-ERR_W-1){d_err[ERR_W]}}, d_err});
   assign inc_raw = $signed({{(INC_W-PT_W){p_term[PT_W-1]}}, p_term})
                    + $signed({{(INC_W-DT_W){d_term[DT_W-1]}}, d_term});

   assign lim_pos = $signed({{(INC_W-ACC_W){1'b0}}, inc_limit_ff, {FRAC_BITS{1'b0}}});
   assign lim_neg = -lim_pos;

   always_comb begin
      if (inc_raw > lim_pos) begin
         inc_clamped = LIM_W'(lim_pos);
      end else if (inc_raw < lim_neg) begin
         inc_clamped = LIM_W'(lim_neg);
      end else begin
         inc_clamped = LIM_W'(inc_raw);
      end
   end

   assign acc_sum = $signed({2'b00, accum_ff})
                    + $signed({{(SUM_W-LIM_W){inc_clamped[LIM_W-1]}}, inc_clamped});
   assign acc_hi  = $signed({2'b00, duty_max_ff, {FRAC_BITS{1'b0}}});
   assign acc_lo  = $signed({2'b00, duty_min_ff, {FRAC_BITS{1'b0}}});

   // upper clamp wins when the limits cross
   always_comb begin
      if (acc_sum > acc_hi) begin
         acc_new = acc_hi[ACC_W-1:0];
      end else if (acc_sum < acc_lo) begin
         acc_new = acc_lo[ACC_W-1:0];
      end else begin
         acc_new = acc_sum[ACC_W-1:0];
      end
   end

   // next control state
   always_comb begin
      dir_in      = dir_ff;
      prev_err_in = prev_err_ff;
      accum_in    = accum_ff;
      duty_in     = duty_ff;
      pins_in     = pins_ff;
      side_rep_in = side_rep_ff;
      phase_in    = phase_ff;

      if (any_side) begin
         prev_err_in = err;
         accum_in    = acc_new;
         duty_in     = acc_new[ACC_W-1:FRAC_BITS];
         if (ccw_run || ccw_brake) begin
            pins_in     = PINS_CCW;
            side_rep_in = SIDE_CCW;
            phase_in    = ccw_run ? PHASE_CCW_RUN : PHASE_CCW_BRAKE;
         end else begin
            pins_in     = PINS_CW;
            side_rep_in = SIDE_CW;
            phase_in    = cw_run ? PHASE_CW_RUN : PHASE_CW_BRAKE;
         end
      end else if (stop_now) begin
         phase_in = PHASE_STOPPED;
      end

      if (stop_now) begin
         pins_in  = PINS_OFF;
         duty_in  = stop_duty_ff;
         accum_in = {stop_duty_ff, {FRAC_BITS{1'b0}}};
         if (brake) begin
            dir_in = ~dir_ff;
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= RST_PROP_GAIN;
         deriv_gain_ff <= RST_DERIV_GAIN;
         inc_limit_ff  <= RST_INC_LIMIT;
         duty_max_ff   <= RST_DUTY_MAX;
         duty_min_ff   <= RST_DUTY_MIN;
         stop_duty_ff  <= RST_STOP_DUTY;
         stop_speed_ff <= RST_STOP_SPEED;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_wdata;
            CSR_DERIV_GAIN: deriv_gain_ff <= csr_wdata;
            CSR_INC_LIMIT:  inc_limit_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_MAX:   duty_max_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_DUTY_MIN:   duty_min_ff   <= csr_wdata[DUTY_W-1:0];
            CSR_STOP_DUTY:  stop_duty_ff  <= csr_wdata[DUTY_W-1:0];
            CSR_STOP_SPEED: stop_speed_ff <= csr_wdata[SPEED_W-1:0];
            default: ;
         endcase
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         side_ff   <= req_side_request;
         target_ff <= req_target_speed;
         meas_ff   <= req_measured_speed;
      end
   end

   // pipeline valids and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         dir_ff       <= DIR_CCW;
         prev_err_ff  <= '0;
         accum_ff     <= '0;
         duty_ff      <= '0;
         pins_ff      <= PINS_OFF;
         side_rep_ff  <= SIDE_NONE;
         phase_ff     <= PHASE_IDLE;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            dir_ff      <= dir_in;
            prev_err_ff <= prev_err_in;
            accum_ff    <= accum_in;
            duty_ff     <= duty_in;
            pins_ff     <= pins_in;
            side_rep_ff <= side_rep_in;
            phase_ff    <= phase_in;
         end
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_drive_a       = pins_ff[0];
   assign rsp_drive_b       = pins_ff[1];
   assign rsp_duty          = duty_ff;
   assign rsp_reported_side = side_rep_ff;
   assign rsp_phase         = phase_ff;
   assign rsp_direction     = dir_ff;

endmodule : dc_motor_pd_reversing_drive

`default_nettype wire

@@ verif/dcpd_drive_checker.sv @@
// Scoreboard for the reversing DC motor drive: predicts every tick result and compares.
// Watches the req, rsp and csr ports and keeps its own copy of registers and loop state.
// Depends on dcpd_pkg.
`timescale 1ns / 1ps

module dcpd_drive_checker
   import dcpd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   input  wire logic                  req_stall,
   input  wire logic [7:0]            req_side_request,
   input  wire logic [SPEED_W-1:0]    req_target_speed,
   input  wire logic [SPEED_W-1:0]    req_measured_speed,
   input  wire logic                  rsp_valid,
   input  wire logic                  rsp_stall,
   input  wire logic                  rsp_drive_a,
   input  wire logic                  rsp_drive_b,
   input  wire logic [DUTY_W-1:0]     rsp_duty,
   input  wire logic [1:0]            rsp_reported_side,
   input  wire logic [2:0]            rsp_phase,
   input  wire logic                  rsp_direction,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         fail_count,
   output int                         pending
);

   typedef struct packed {
      logic              drive_a;
      logic              drive_b;
      logic [DUTY_W-1:0] duty;
      logic [1:0]        side;
      logic [2:0]        phase;
      logic              dir;
   } drive_beat_t;

   drive_beat_t expected_ticks[$];
   int          failures = 0;
   int          rsp_beats = 0;

   // register copies
   logic [GAIN_W-1:0]  kp, kd;
   logic [DUTY_W-1:0]  inc_lim, dmax, dmin, sduty;
   logic [SPEED_W-1:0] sspeed;

   // loop state
   logic                     dir_q;
   logic signed [ERR_W-1:0]  prev_err;
   logic [ACC_W-1:0]         accum;
   logic [DUTY_W-1:0]        duty_q;
   logic [1:0]               pins_q;  // {drive_b, drive_a}
   logic [1:0]               side_q;
   logic [2:0]               phase_q;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void pd_step(input logic [SPEED_W-1:0] tgt,
                                   input logic [SPEED_W-1:0] meas);
      longint err, incr, lim, sum, hi, lo;
      err  = longint'(tgt) - longint'(meas);
      incr = longint'(kp) * err + longint'(kd) * (err - longint'(prev_err));
      lim  = longint'(inc_lim) * 256;
      if (incr > lim) begin
         incr = lim;
      end else if (incr < -lim) begin
         incr = -lim;
      end
      prev_err = err[ERR_W-1:0];
      hi  = longint'(dmax) * 256;
      lo  = longint'(dmin) * 256;
      sum = longint'(accum) + incr;
      // upper bound wins when the clamps are crossed
      if (sum > hi) begin
         sum = hi;
      end else if (sum < lo) begin
         sum = lo;
      end
      accum  = sum[ACC_W-1:0];
      duty_q = accum[ACC_W-1:FRAC_BITS];
   endfunction

   function automatic void stop_drive();
      pins_q = PINS_OFF;
      duty_q = sduty;
      accum  = {sduty, {FRAC_BITS{1'b0}}};
   endfunction

   function automatic drive_beat_t predict_tick(input logic [7:0]         side,
                                                input logic [SPEED_W-1:0] tgt,
                                                input logic [SPEED_W-1:0] meas);
      drive_beat_t r;
      if (side == REQ_CCW && dir_q == DIR_CCW) begin
         pins_q = PINS_CCW;
         side_q = SIDE_CCW;
         pd_step(tgt, meas);
         phase_q = PHASE_CCW_RUN;
      end else if (side == REQ_CW && dir_q == DIR_CCW) begin
         phase_q = PHASE_CCW_BRAKE;
         pins_q  = PINS_CCW;
         side_q  = SIDE_CCW;
         pd_step('0, meas);
         if (meas <= sspeed) begin
            stop_drive();
            dir_q = DIR_CW;
         end
      end else if (side == REQ_CW) begin
         pins_q = PINS_CW;
         side_q = SIDE_CW;
         pd_step(tgt, meas);
         phase_q = PHASE_CW_RUN;
      end else if (side == REQ_CCW) begin
         phase_q = PHASE_CW_BRAKE;
         pins_q  = PINS_CW;
         side_q  = SIDE_CW;
         pd_step('0, meas);
         if (meas <= sspeed) begin
            stop_drive();
            dir_q = DIR_CCW;
         end
      end else if (tgt == '0) begin
         phase_q = PHASE_STOPPED;
         stop_drive();
      end
      // neither side with a nonzero target leaves everything as held
      r.drive_a = pins_q[0];
      r.drive_b = pins_q[1];
      r.duty    = duty_q;
      r.side    = side_q;
      r.phase   = phase_q;
      r.dir     = dir_q;
      return r;
   endfunction

   always @(posedge clock) begin
      drive_beat_t seen, want;
      if (reset) begin
         kp       = RST_PROP_GAIN;
         kd       = RST_DERIV_GAIN;
         inc_lim  = RST_INC_LIMIT;
         dmax     = RST_DUTY_MAX;
         dmin     = RST_DUTY_MIN;
         sduty    = RST_STOP_DUTY;
         sspeed   = RST_STOP_SPEED;
         dir_q    = DIR_CCW;
         prev_err = '0;
         accum    = '0;
         duty_q   = '0;
         pins_q   = PINS_OFF;
         side_q   = SIDE_NONE;
         phase_q  = PHASE_IDLE;
         expected_ticks.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_drive_a, rsp_drive_b, rsp_duty, rsp_reported_side,
                     rsp_phase, rsp_direction};
            if (expected_ticks.size() == 0) begin
               failures++;
               if (failures <= 10)
                  $display("rsp beat %0d arrived with no tick outstanding", rsp_beats);
            end else begin
               want = expected_ticks.pop_front();
               if (seen.drive_a !== want.drive_a || seen.drive_b !== want.drive_b ||
                   seen.duty !== want.duty || seen.side !== want.side ||
                   seen.phase !== want.phase || seen.dir !== want.dir) begin
                  failures++;
                  if (failures <= 10)
                     $display({"rsp beat %0d mismatch: exp a=%0d b=%0d duty=%0d side=%0d ",
                               "phase=%0d dir=%0d / got a=%0d b=%0d duty=%0d side=%0d ",
                               "phase=%0d dir=%0d"}, rsp_beats,
                              want.drive_a, want.drive_b, want.duty, want.side,
                              want.phase, want.dir, seen.drive_a, seen.drive_b,
                              seen.duty, seen.side, seen.phase, seen.dir);
               end
            end
            rsp_beats++;
         end
         if (req_valid && !req_stall)
            expected_ticks.push_back(predict_tick(req_side_request, req_target_speed,
                                                  req_measured_speed));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROP_GAIN:  kp      = csr_wdata[GAIN_W-1:0];
               CSR_DERIV_GAIN: kd      = csr_wdata[GAIN_W-1:0];
               CSR_INC_LIMIT:  inc_lim = csr_wdata[DUTY_W-1:0];
               CSR_DUTY_MAX:   dmax    = csr_wdata[DUTY_W-1:0];
               CSR_DUTY_MIN:   dmin    = csr_wdata[DUTY_W-1:0];
               CSR_STOP_DUTY:  sduty   = csr_wdata[DUTY_W-1:0];
               CSR_STOP_SPEED: sspeed  = csr_wdata[SPEED_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count <= failures;
      pending    <= expected_ticks.size();
   end

endmodule : dcpd_drive_checker

@@ verif/tb_dc_motor_pd_reversing_drive.sv @@
// Testbench top for the reversing DC motor drive: clock, reset, tick and register stimulus.
// Directed ticks, then random run/brake/reverse sequences over six register settings.
// Depends on dcpd_pkg, dc_motor_pd_reversing_drive and dcpd_drive_checker.
`timescale 1ns / 1ps

module tb_dc_motor_pd_reversing_drive;
   import dcpd_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 3'd7;
   localparam int TICKS_PER_SETTING = 225;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_side_request = '0;
   logic [SPEED_W-1:0]    req_target_speed = '0;
   logic [SPEED_W-1:0]    req_measured_speed = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_drive_a;
   logic                  rsp_drive_b;
   logic [DUTY_W-1:0]     rsp_duty;
   logic [1:0]            rsp_reported_side;
   logic [2:0]            rsp_phase;
   logic                  rsp_direction;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    fail_count;
   int                    pending;

   int send_idle_pct = 0;
   int stall_pct = 0;

   dc_motor_pd_reversing_drive i_dut (.*);
   dcpd_drive_checker i_checker (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   task automatic send_tick(input logic [7:0]         side,
                            input logic [SPEED_W-1:0] tgt,
                            input logic [SPEED_W-1:0] meas);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid          <= 1'b1;
      req_side_request   <= side;
      req_target_speed   <= tgt;
      req_measured_speed <= meas;
      do @(posedge clock); while (req_stall);
   endtask

   // wait until every tick has its result, then a little longer for the pipeline
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic configure(input int setting);
      logic [CSR_DATA_W-1:0] kp, kd, lim, dmax, dmin, sduty, sspeed;
      case (setting)
         0: begin
            // reset values with junk above each register's width
            kp     = RST_PROP_GAIN;
            kd     = RST_DERIV_GAIN;
            lim    = {4'($urandom), RST_INC_LIMIT};
            dmax   = {4'($urandom), RST_DUTY_MAX};
            dmin   = {4'($urandom), RST_DUTY_MIN};
            sduty  = {4'($urandom), RST_STOP_DUTY};
            sspeed = {8'($urandom), RST_STOP_SPEED};
         end
         2: begin
            kp = '1; kd = '1; lim = '1; dmax = '1; dmin = '1; sduty = '1; sspeed = '1;
         end
         3: begin
            // crossed clamps
            kp     = CSR_DATA_W'($urandom);
            kd     = CSR_DATA_W'($urandom);
            lim    = CSR_DATA_W'($urandom_range(4095));
            dmax   = CSR_DATA_W'($urandom_range(1500));
            dmin   = CSR_DATA_W'($urandom_range(4095, 2000));
            sduty  = CSR_DATA_W'($urandom_range(4095));
            sspeed = CSR_DATA_W'($urandom_range(30));
         end
         4: begin
            kp = '0; kd = '0; lim = '0; dmax = '0; dmin = '0; sduty = '0; sspeed = '0;
         end
         default: begin
            kp     = CSR_DATA_W'($urandom_range(1024));
            kd     = CSR_DATA_W'($urandom_range(1024));
            lim    = CSR_DATA_W'($urandom_range(4095));
            dmax   = CSR_DATA_W'($urandom_range(4095, 2048));
            dmin   = CSR_DATA_W'($urandom_range(1024));
            sduty  = CSR_DATA_W'($urandom_range(4095));
            sspeed = CSR_DATA_W'($urandom_range(40));
         end
      endcase
      write_reg(CSR_PROP_GAIN, kp);
      write_reg(CSR_DERIV_GAIN, kd);
      write_reg(CSR_INC_LIMIT, lim);
      write_reg(CSR_DUTY_MAX, dmax);
      write_reg(CSR_DUTY_MIN, dmin);
      write_reg(CSR_STOP_DUTY, sduty);
      write_reg(CSR_STOP_SPEED, sspeed);
      write_reg(CSR_UNUSED_IDX, CSR_DATA_W'($urandom));
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // runs in one direction, reversals with the speed falling away, some noise ticks
   task automatic drive_random(input int count);
      logic [7:0] side;
      int         goal, speed, step, roll;
      side  = REQ_CCW;
      goal  = $urandom_range(255);
      speed = $urandom_range(255);
      for (int k = 0; k < count; k++) begin
         roll = $urandom_range(99);
         if (roll < 7) begin
            side = (side == REQ_CCW) ? REQ_CW : REQ_CCW;
            goal = $urandom_range(255);
         end else if (roll < 12) begin
            goal = $urandom_range(255);
         end
         roll = $urandom_range(99);
         step = $urandom_range(60);
         if (roll < 30) begin
            speed = (speed > step) ? speed - step : 0;
         end else if (roll < 35) begin
            speed = $urandom_range(255);
         end else if (speed < goal) begin
            speed = (goal - speed > step / 3) ? speed + step / 3 : goal;
         end else begin
            speed = (speed - goal > step / 3) ? speed - step / 3 : goal;
         end
         if ($urandom_range(99) < 12)
            send_tick(8'($urandom_range(255, 2)),
                      $urandom_range(1) ? 8'd0 : 8'($urandom), 8'($urandom));
         else
            send_tick(side, 8'(goal), 8'(speed));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 13;
      stall_pct     = 74;
      send_tick(REQ_CCW, 0, 0);
      repeat (8) send_tick(REQ_CCW, 255, 0);     // ramps up against the increment clamp
      send_tick(REQ_CCW, 0, 255);
      send_tick(REQ_CW, 100, 200);               // brake, still fast
      send_tick(REQ_CW, 50, RST_STOP_SPEED);     // brake ends on the threshold, flip to cw
      send_tick(REQ_CW, 255, 0);
      send_tick(REQ_CW, 255, 255);
      send_tick(REQ_CCW, 0, RST_STOP_SPEED + 8'd1);
      send_tick(REQ_CCW, 0, 0);                  // flip back to ccw
      send_tick(8'h02, 7, 7);                    // neither side, holds
      send_tick(8'hFF, 0, 255);                  // neither side, stops
      send_tick(8'h80, 255, 0);
      send_tick(REQ_CCW, 255, 255);
      send_tick(8'hFE, 0, 0);
      send_tick(REQ_CW, 0, 255);
      send_tick(REQ_CW, 0, 255);

      for (int setting = 0; setting < 6; setting++) begin
         case (setting / 2)
            0: begin send_idle_pct = 13; stall_pct = 74; end
            1: begin send_idle_pct = 74; stall_pct = 13; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         drain();
         configure(setting);
         drive_random(TICKS_PER_SETTING);
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule : tb_dc_motor_pd_reversing_drive

@@ files.f @@
hdl/dcpd_pkg.sv
hdl/dc_motor_pd_reversing_drive.sv
verif/dcpd_drive_checker.sv
verif/tb_dc_motor_pd_reversing_drive.sv
